[rtl/hsl2rgb_pkg.sv]
// Shared types, constants and helper functions for the HSL to RGB converter.
`timescale 1ns / 1ps
`default_nettype none

package hsl2rgb_pkg;

	// Fixed field widths.
	localparam int HUE_W = 13;
	localparam int CH_W  = 8;

	// Hue format: degrees with this many fraction bits.
	localparam int HUE_FRAC_BITS = 4;

	// One 60-degree sector in hue units, and the largest code the hue port can carry.
	localparam int HUE_SECTOR = 60 << HUE_FRAC_BITS;
	localparam int HUE_MAX    = (1 << HUE_W) - 1;

	// Highest sector index that a raw hue code can reach before the 360-degree wrap.
	localparam int THR_MAX = HUE_MAX / HUE_SECTOR;

	// Position inside the 120-degree period, and the triangle weight derived from it.
	localparam int U_W = $clog2(2 * HUE_SECTOR);
	localparam int W_W = $clog2(HUE_SECTOR + 1);

	// Chroma numerator (255 - |2L - 255|) * S and the product with the weight.
	localparam int CN_W = 16;
	localparam int P_W  = CN_W + W_W;
	localparam int V_W  = P_W - HUE_FRAC_BITS;

	// floor(2 * Cn * W / D) = floor((Cn * W >> frac) / X_DIV).
	localparam int X_DIV = HUE_SECTOR / (1 << (HUE_FRAC_BITS + 1));

	// Reciprocal of X_DIV, truncated; the estimate is low by at most one.
	localparam int RECIP_SH = V_W + 5;
	localparam longint RECIP_VAL = (longint'(1) << RECIP_SH) / X_DIV;
	localparam int M_W = $clog2(RECIP_VAL + 1);
	localparam logic [M_W-1:0] RECIP_M = M_W'(RECIP_VAL);

	// Channel numerators over 510 fit in 17 bits (at most 130050).
	localparam int Q_W = 17;

	// Pipeline depth, output register included.
	localparam int N_STAGES = 6;

	// 60-degree hue sectors, named by the hues they run between.
	typedef enum logic [2:0] {
		SECT_RED_YEL = 3'd0,
		SECT_YEL_GRN = 3'd1,
		SECT_GRN_CYN = 3'd2,
		SECT_CYN_BLU = 3'd3,
		SECT_BLU_MAG = 3'd4,
		SECT_MAG_RED = 3'd5
	} sector_t;

	// Per-stage load enables and valid flags from the pipeline control.
	typedef struct packed {
		logic [N_STAGES-1:0] load;
		logic [N_STAGES-1:0] valid;
	} pipe_ctl_t;

	// floor(q / 510) for q up to 130050, done as floor((q >> 1) / 255) with the
	// add-and-shift identity that is exact for dividends below 65535.
	function automatic logic [CH_W-1:0] div510(input logic [Q_W-1:0] q);
		logic [15:0] x;
		logic [16:0] sum;
		x   = q[Q_W-1:1];
		sum = 17'(x) + 17'd1 + 17'(x[15:8]);
		return sum[15:8];
	endfunction

endpackage

`default_nettype wire

[rtl/hsl2rgb_pipe_ctrl.sv]
// Valid tracking and stall propagation for the converter pipeline.
`timescale 1ns / 1ps
`default_nettype none

module hsl2rgb_pipe_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  hsl_valid,
	output logic                       hsl_stall,
	input  wire logic                  rgb_stall,
	output hsl2rgb_pkg::pipe_ctl_t     ctl
);

	localparam int N = hsl2rgb_pkg::N_STAGES;

	logic [N-1:0] valid_q;
	logic [N-1:0] ready;

	// A stage can load when it is empty or when the stage after it moves on,
	// so bubbles collapse while the output is stalled.
	always_comb begin
		ready[N-1] = !valid_q[N-1] || !rgb_stall;
		for (int k = N - 2; k >= 0; k--) begin
			ready[k] = !valid_q[k] || ready[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (ready[0]) begin
				valid_q[0] <= hsl_valid;
			end
			for (int k = 1; k < N; k++) begin
				if (ready[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	assign hsl_stall = !ready[0];
	assign ctl.load  = ready;
	assign ctl.valid = valid_q;

endmodule

`default_nettype wire

[rtl/hsl2rgb_hue_map.sv]
// Hue wrap, 60-degree sector index and position within the 120-degree period.
`timescale 1ns / 1ps
`default_nettype none

module hsl2rgb_hue_map (
	input  wire logic [hsl2rgb_pkg::HUE_W-1:0] hue,
	output hsl2rgb_pkg::sector_t               sector,
	output logic [hsl2rgb_pkg::U_W-1:0]        pos
);

	localparam int HW  = hsl2rgb_pkg::HUE_W;
	localparam int UW  = hsl2rgb_pkg::U_W;
	localparam int D   = hsl2rgb_pkg::HUE_SECTOR;
	localparam int THR = hsl2rgb_pkg::THR_MAX;

	logic [THR:0]  ge;
	logic [UW-1:0] cand_pos [THR+1];
	hsl2rgb_pkg::sector_t cand_sect [THR+1];

	// One comparator per sector boundary; the boundaries are constants, so
	// the sector index and the start of its 120-degree period are too.
	for (genvar k = 0; k <= THR; k++) begin : g_thr
		localparam int LO   = k * D;
		localparam int BASE = (k / 2) * 2 * D;
		localparam int SECT = k % 6;
		assign ge[k]        = (hue >= HW'(LO));
		assign cand_pos[k]  = UW'(hue - HW'(BASE));
		assign cand_sect[k] = hsl2rgb_pkg::sector_t'(3'(SECT));
	end

	// The boundaries form a thermometer code; the highest one passed wins.
	always_comb begin
		sector = cand_sect[0];
		pos    = cand_pos[0];
		for (int k = 1; k <= THR; k++) begin
			if (ge[k]) begin
				sector = cand_sect[k];
				pos    = cand_pos[k];
			end
		end
	end

endmodule

`default_nettype wire

[rtl/hsl_to_rgb_converter_unit.sv]
// Top level of the HSL to RGB converter: six-stage datapath and its handshakes.
`timescale 1ns / 1ps
`default_nettype none

// HSL to RGBA converter. Each transfer on the hsl channel carries a hue in
// sixteenths of a degree together with saturation, lightness and alpha as
// k/255 fractions; each transfer on the rgb channel returns the matching
// 8-bit red, green and blue, each equal to the floor of the exact rational
// result, with alpha passed through untouched. Hue codes at or beyond 360
// degrees wrap around. The block takes one transfer per clock cycle while
// hsl_stall is low and returns each result through six register stages:
// hue decode, chroma product, chroma-times-weight product, reciprocal
// estimate of the divide by the sector scale, its correction, and the final
// divide by 510 into the output register. A stall on the rgb side holds the
// output register; earlier stages keep filling empty slots, so the hsl side
// stalls only once every stage holds an item. There is no configuration and
// no state beyond the pipeline, and reset only empties the pipeline.
module hsl_to_rgb_converter_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,

	input  wire logic                              hsl_valid,
	output logic                                   hsl_stall,
	input  wire logic [hsl2rgb_pkg::HUE_W-1:0]     hue,
	input  wire logic [hsl2rgb_pkg::CH_W-1:0]      saturation,
	input  wire logic [hsl2rgb_pkg::CH_W-1:0]      lightness,
	input  wire logic [hsl2rgb_pkg::CH_W-1:0]      alpha_in,

	output logic                                   rgb_valid,
	input  wire logic                              rgb_stall,
	output logic [hsl2rgb_pkg::CH_W-1:0]           red,
	output logic [hsl2rgb_pkg::CH_W-1:0]           green,
	output logic [hsl2rgb_pkg::CH_W-1:0]           blue,
	output logic [hsl2rgb_pkg::CH_W-1:0]           alpha_out
);

	localparam int CW    = hsl2rgb_pkg::CH_W;
	localparam int UW    = hsl2rgb_pkg::U_W;
	localparam int WW    = hsl2rgb_pkg::W_W;
	localparam int CNW   = hsl2rgb_pkg::CN_W;
	localparam int PW    = hsl2rgb_pkg::P_W;
	localparam int VW    = hsl2rgb_pkg::V_W;
	localparam int MW    = hsl2rgb_pkg::M_W;
	localparam int QW    = hsl2rgb_pkg::Q_W;
	localparam int FRAC  = hsl2rgb_pkg::HUE_FRAC_BITS;
	localparam int D     = hsl2rgb_pkg::HUE_SECTOR;
	localparam int XDIV  = hsl2rgb_pkg::X_DIV;
	localparam int RSH   = hsl2rgb_pkg::RECIP_SH;
	localparam int LAST  = hsl2rgb_pkg::N_STAGES - 1;

	hsl2rgb_pkg::pipe_ctl_t ctl;

	hsl2rgb_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.hsl_valid (hsl_valid),
		.hsl_stall (hsl_stall),
		.rgb_stall (rgb_stall),
		.ctl       (ctl)
	);

	// ---------------------------------------------------------------------
	// Stage 1: wrap the hue and find its sector and its position inside the
	// 120-degree period; fold lightness into the chroma scale
	// 255 - |2L - 255|, which never exceeds 254.
	// ---------------------------------------------------------------------
	hsl2rgb_pkg::sector_t sector_c;
	logic [UW-1:0]        pos_c;
	logic [8:0]           light_x2;
	logic [CW-1:0]        cm_c;

	hsl2rgb_hue_map u_hue_map (
		.hue    (hue),
		.sector (sector_c),
		.pos    (pos_c)
	);

	assign light_x2 = {lightness, 1'b0};
	assign cm_c     = lightness[CW-1] ? CW'(9'd510 - light_x2) : light_x2[CW-1:0];

	hsl2rgb_pkg::sector_t sector_s1;
	logic [UW-1:0]        pos_s1;
	logic [CW-1:0]        cm_s1;
	logic [CW-1:0]        sat_s1;
	logic [CW-1:0]        light_s1;
	logic [CW-1:0]        alpha_s1;

	always_ff @(posedge clk) begin
		if (ctl.load[0]) begin
			sector_s1 <= sector_c;
			pos_s1    <= pos_c;
			cm_s1     <= cm_c;
			sat_s1    <= saturation;
			light_s1  <= lightness;
			alpha_s1  <= alpha_in;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 2: chroma numerator Cn = cm * S (c = Cn / 65025) and the
	// triangle weight W = D - |pos - D|, which runs 0..D..0 over the period.
	// ---------------------------------------------------------------------
	logic [UW-1:0] dist_c;
	logic [WW-1:0] w_c;

	always_comb begin
		if (pos_s1 >= UW'(D)) begin
			dist_c = pos_s1 - UW'(D);
		end else begin
			dist_c = UW'(D) - pos_s1;
		end
		w_c = WW'(D) - WW'(dist_c);
	end

	hsl2rgb_pkg::sector_t sector_s2;
	logic [CNW-1:0]       cn_s2;
	logic [WW-1:0]        w_s2;
	logic [CW-1:0]        light_s2;
	logic [CW-1:0]        alpha_s2;

	always_ff @(posedge clk) begin
		if (ctl.load[1]) begin
			sector_s2 <= sector_s1;
			cn_s2     <= CNW'(cm_s1) * CNW'(sat_s1);
			w_s2      <= w_c;
			light_s2  <= light_s1;
			alpha_s2  <= alpha_s1;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 3: every channel is floor(N / 510) with
	//   full chroma  N = 510L + Cn
	//   zero         N = 510L - Cn   (never negative)
	//   x component  N = 510L - Cn + floor(2 * Cn * W / D)
	// Here the product Cn * W is formed and its fraction bits dropped, and
	// the two fixed numerators are built.
	// ---------------------------------------------------------------------
	logic [PW-1:0] p_c;
	logic [QW-1:0] l510_c;

	assign p_c    = PW'(cn_s2) * PW'(w_s2);
	assign l510_c = QW'({light_s2, 9'b0}) - QW'({light_s2, 1'b0});

	hsl2rgb_pkg::sector_t sector_s3;
	logic [VW-1:0]        v_s3;
	logic [QW-1:0]        qc_s3;
	logic [QW-1:0]        qz_s3;
	logic [CW-1:0]        alpha_s3;

	always_ff @(posedge clk) begin
		if (ctl.load[2]) begin
			sector_s3 <= sector_s2;
			v_s3      <= p_c[PW-1:FRAC];
			qc_s3     <= l510_c + QW'(cn_s2);
			qz_s3     <= l510_c - QW'(cn_s2);
			alpha_s3  <= alpha_s2;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 4: quotient estimate of v / XDIV by the truncated reciprocal.
	// The estimate is either exact or one short.
	// ---------------------------------------------------------------------
	logic [VW+MW-1:0] est_prod;

	assign est_prod = (VW + MW)'(v_s3) * (VW + MW)'(hsl2rgb_pkg::RECIP_M);

	hsl2rgb_pkg::sector_t sector_s4;
	logic [VW-1:0]        v_s4;
	logic [QW-1:0]        t0_s4;
	logic [QW-1:0]        qc_s4;
	logic [QW-1:0]        qz_s4;
	logic [CW-1:0]        alpha_s4;

	always_ff @(posedge clk) begin
		if (ctl.load[3]) begin
			sector_s4 <= sector_s3;
			v_s4      <= v_s3;
			t0_s4     <= QW'(est_prod >> RSH);
			qc_s4     <= qc_s3;
			qz_s4     <= qz_s3;
			alpha_s4  <= alpha_s3;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 5: correct the estimate with one compare on the remainder, then
	// add the zero-channel numerator to get the x-channel numerator.
	// ---------------------------------------------------------------------
	logic [VW-1:0] rem_c;
	logic          bump_c;
	logic [QW-1:0] t_c;

	assign rem_c  = v_s4 - VW'(t0_s4) * VW'(XDIV);
	assign bump_c = (rem_c >= VW'(XDIV));
	assign t_c    = t0_s4 + QW'(bump_c);

	hsl2rgb_pkg::sector_t sector_s5;
	logic [QW-1:0]        qx_s5;
	logic [QW-1:0]        qc_s5;
	logic [QW-1:0]        qz_s5;
	logic [CW-1:0]        alpha_s5;

	always_ff @(posedge clk) begin
		if (ctl.load[4]) begin
			sector_s5 <= sector_s4;
			qx_s5     <= t_c + qz_s4;
			qc_s5     <= qc_s4;
			qz_s5     <= qz_s4;
			alpha_s5  <= alpha_s4;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 6: divide by 510 and route (c, x, 0) to red, green and blue by
	// sector. The numerators are bounded by 130050, so no channel ever
	// leaves 0..255 and no clamp is needed. This is the output register.
	// ---------------------------------------------------------------------
	logic [CW-1:0] ch_c;
	logic [CW-1:0] ch_x;
	logic [CW-1:0] ch_z;
	logic [CW-1:0] red_c;
	logic [CW-1:0] green_c;
	logic [CW-1:0] blue_c;

	assign ch_c = hsl2rgb_pkg::div510(qc_s5);
	assign ch_x = hsl2rgb_pkg::div510(qx_s5);
	assign ch_z = hsl2rgb_pkg::div510(qz_s5);

	always_comb begin
		case (sector_s5)
			hsl2rgb_pkg::SECT_RED_YEL: begin
				red_c = ch_c; green_c = ch_x; blue_c = ch_z;
			end
			hsl2rgb_pkg::SECT_YEL_GRN: begin
				red_c = ch_x; green_c = ch_c; blue_c = ch_z;
			end
			hsl2rgb_pkg::SECT_GRN_CYN: begin
				red_c = ch_z; green_c = ch_c; blue_c = ch_x;
			end
			hsl2rgb_pkg::SECT_CYN_BLU: begin
				red_c = ch_z; green_c = ch_x; blue_c = ch_c;
			end
			hsl2rgb_pkg::SECT_BLU_MAG: begin
				red_c = ch_x; green_c = ch_z; blue_c = ch_c;
			end
			hsl2rgb_pkg::SECT_MAG_RED: begin
				red_c = ch_c; green_c = ch_z; blue_c = ch_x;
			end
			default: begin
				red_c = ch_c; green_c = ch_z; blue_c = ch_x;
			end
		endcase
	end

	logic [CW-1:0] red_s6;
	logic [CW-1:0] green_s6;
	logic [CW-1:0] blue_s6;
	logic [CW-1:0] alpha_s6;

	always_ff @(posedge clk) begin
		if (ctl.load[5]) begin
			red_s6   <= red_c;
			green_s6 <= green_c;
			blue_s6  <= blue_c;
			alpha_s6 <= alpha_s5;
		end
	end

	assign rgb_valid = ctl.valid[LAST];
	assign red       = red_s6;
	assign green     = green_s6;
	assign blue      = blue_s6;
	assign alpha_out = alpha_s6;

endmodule

`default_nettype wire
